// ===== rtl/ray_box_slab_intersect_assert.svh =====
// Assertion macros for the checker file of the ray/box slab block.
// Depends on nothing; the including scope provides clk and rst.
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// Check a property every clock edge outside reset.
`define RBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property every clock edge, reset included.
`define RBS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rbs_pkg.sv =====
// Shared types, constants and saturation helper for the ray/box slab block.
// Depends on nothing; every module of the block imports it.
package rbs_pkg;

  localparam int FRAC_BITS = 16;
  // quotient bits of 2^(2*FRAC_BITS) / |dir|
  localparam int DIV_BITS  = 2 * FRAC_BITS + 1;
  localparam logic [DIV_BITS-1:0] DIVIDEND = DIV_BITS'(1) << (2 * FRAC_BITS);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_THR = CFG_IDX_W'(1);

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] off_t;

  localparam coord_t COORD_MAX = 32'sh7fffffff;
  localparam coord_t COORD_MIN = 32'sh80000000;
  localparam coord_t TIME_ONE  = 32'sd1 <<< FRAC_BITS;

  localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
  localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t vector_x;
    coord_t vector_y;
    coord_t vector_z;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } in_t;

  typedef struct packed {
    logic   hit;
    coord_t hit_time;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } out_t;

  // per-item data after input preparation
  typedef struct packed {
    coord_t [2:0]      o;
    coord_t [2:0]      d;
    logic [2:0][31:0]  mag;
    logic [2:0]        neg;
    off_t [2:0]        lo_off;
    off_t [2:0]        hi_off;
    logic [2:0]        par;
    logic [2:0]        outside;
    logic              in_box;
  } prep_t;

  // result of the slab test, input to the entry point stage
  typedef struct packed {
    logic         hit;
    coord_t       hit_time;
    coord_t [2:0] o;
    coord_t [2:0] d;
  } slab_t;

  function automatic coord_t sat_coord(input logic signed [65:0] v);
    coord_t r;
    if (v > WIDE_MAX) begin
      r = COORD_MAX;
    end else if (v < WIDE_MIN) begin
      r = COORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/rbs_prep.sv =====
// Input stage: direction, inside test, parallel flags and bound offsets.
// Depends on rbs_pkg.
module rbs_prep import rbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  in_t         in_data,
  input  logic        segment_mode,
  input  logic [15:0] parallel_threshold,
  output logic        valid,
  output prep_t       beat
);

  prep_t  beat_next;
  coord_t o [3];
  coord_t v [3];
  coord_t lo [3];
  coord_t hi [3];

  assign o  = '{in_data.origin_x, in_data.origin_y, in_data.origin_z};
  assign v  = '{in_data.vector_x, in_data.vector_y, in_data.vector_z};
  assign lo = '{in_data.box_min_x, in_data.box_min_y, in_data.box_min_z};
  assign hi = '{in_data.box_max_x, in_data.box_max_y, in_data.box_max_z};

  // form direction and per-axis flags
  always_comb begin
    beat_next = '0;
    for (int i = 0; i < 3; i++) begin
      if (segment_mode) begin
        beat_next.d[i] = sat_coord(66'(v[i]) - 66'(o[i]));
      end else begin
        beat_next.d[i] = v[i];
      end
      beat_next.o[i]       = o[i];
      beat_next.neg[i]     = beat_next.d[i][31];
      beat_next.mag[i]     = beat_next.d[i][31] ? 32'(-beat_next.d[i]) : beat_next.d[i];
      beat_next.par[i]     = (beat_next.d[i] == '0) ||
                             (beat_next.mag[i] < {16'd0, parallel_threshold});
      beat_next.outside[i] = (o[i] < lo[i]) || (o[i] > hi[i]);
      beat_next.lo_off[i]  = 33'(lo[i]) - 33'(o[i]);
      beat_next.hi_off[i]  = 33'(hi[i]) - 33'(o[i]);
    end
    beat_next.in_box = ~|beat_next.outside;
  end

  // advance stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
    if (en) begin
      beat <= beat_next;
    end
  end

endmodule

// ===== rtl/rbs_recip.sv =====
// Pipelined restoring divider: one quotient bit per stage, three axes.
// Depends on rbs_pkg; carries the prepared item alongside.
module rbs_recip import rbs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  prep_t        in_beat,
  output logic         valid,
  output prep_t        beat,
  output coord_t [2:0] recip
);

  logic                          vld  [DIV_BITS+1];
  prep_t                         side [DIV_BITS+1];
  logic [2:0][31:0]              rem  [DIV_BITS+1];
  logic [2:0][DIV_BITS-1:0]      quo  [DIV_BITS+1];

  assign vld[0]  = in_valid;
  assign side[0] = in_beat;
  assign rem[0]  = '0;
  assign quo[0]  = '0;

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    logic [2:0][31:0]         rem_next;
    logic [2:0][DIV_BITS-1:0] quo_next;

    // shift in one dividend bit, subtract where it fits
    always_comb begin
      logic [32:0] trial;
      for (int i = 0; i < 3; i++) begin
        trial = {rem[k][i], DIVIDEND[DIV_BITS-1-k]};
        if (trial >= {1'b0, side[k].mag[i]}) begin
          rem_next[i] = 32'(trial - {1'b0, side[k].mag[i]});
          quo_next[i] = {quo[k][i][DIV_BITS-2:0], 1'b1};
        end else begin
          rem_next[i] = trial[31:0];
          quo_next[i] = {quo[k][i][DIV_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        side[k+1] <= side[k];
        rem[k+1]  <= rem_next;
        quo[k+1]  <= quo_next;
      end
    end
  end

  // apply sign and saturate the quotient
  coord_t [2:0] recip_next;
  always_comb begin
    logic signed [DIV_BITS:0] sq;
    for (int i = 0; i < 3; i++) begin
      sq = $signed({1'b0, quo[DIV_BITS][i]});
      if (side[DIV_BITS].neg[i]) begin
        sq = -sq;
      end
      recip_next[i] = sat_coord(66'(sq));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= vld[DIV_BITS];
    end
    if (en) begin
      beat  <= side[DIV_BITS];
      recip <= recip_next;
    end
  end

endmodule

// ===== rtl/rbs_slab.sv =====
// Slab times per axis, then the interval merge and the hit decision.
// Depends on rbs_pkg; three register stages.
module rbs_slab import rbs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         segment_mode,
  input  logic         in_valid,
  input  prep_t        in_beat,
  input  coord_t [2:0] recip,
  output logic         valid,
  output slab_t        beat
);

  // stage A: bound offset times reciprocal
  logic                    a_valid;
  prep_t                   a_beat;
  logic signed [2:0][64:0] a_plo;
  logic signed [2:0][64:0] a_phi;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_beat <= in_beat;
      for (int i = 0; i < 3; i++) begin
        a_plo[i] <= 65'(in_beat.lo_off[i]) * 65'(recip[i]);
        a_phi[i] <= 65'(in_beat.hi_off[i]) * 65'(recip[i]);
      end
    end
  end

  // stage B: scale, saturate and order the two slab times
  logic         b_valid;
  prep_t        b_beat;
  coord_t [2:0] b_tn;
  coord_t [2:0] b_tf;
  coord_t [2:0] tn_next;
  coord_t [2:0] tf_next;

  always_comb begin
    coord_t hn;
    coord_t hf;
    for (int i = 0; i < 3; i++) begin
      hn = sat_coord(66'($signed(a_plo[i]) >>> FRAC_BITS));
      hf = sat_coord(66'($signed(a_phi[i]) >>> FRAC_BITS));
      if (hn > hf) begin
        tn_next[i] = hf;
        tf_next[i] = hn;
      end else begin
        tn_next[i] = hn;
        tf_next[i] = hf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_beat <= a_beat;
      b_tn   <= tn_next;
      b_tf   <= tf_next;
    end
  end

  // stage C: merge intervals of the non-parallel axes and decide
  slab_t beat_next;
  always_comb begin
    coord_t tnear;
    coord_t tfar;
    logic   miss;
    tnear = COORD_MIN;
    tfar  = COORD_MAX;
    miss  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (b_beat.par[i]) begin
        miss = miss | b_beat.outside[i];
      end else begin
        if (b_tn[i] > tnear) begin
          tnear = b_tn[i];
        end
        if (b_tf[i] < tfar) begin
          tfar = b_tf[i];
        end
      end
    end
    miss = miss || (tnear > tfar) || (tfar < 0) || (segment_mode && (tnear > TIME_ONE));
    beat_next.o = b_beat.o;
    beat_next.d = b_beat.d;
    if (b_beat.in_box) begin
      beat_next.hit      = 1'b1;
      beat_next.hit_time = '0;
    end else begin
      beat_next.hit      = ~miss;
      beat_next.hit_time = tnear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= b_valid;
    end
    if (en) begin
      beat <= beat_next;
    end
  end

endmodule

// ===== rtl/rbs_point.sv =====
// Entry point: direction times entry time, scaled, added to the origin.
// Depends on rbs_pkg; two register stages, the second is the output register.
module rbs_point import rbs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  slab_t in_beat,
  output logic  valid,
  output out_t  beat
);

  // stage D: direction times entry time
  logic                    d_valid;
  slab_t                   d_beat;
  logic signed [2:0][63:0] d_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= in_valid;
    end
    if (en) begin
      d_beat <= in_beat;
      for (int i = 0; i < 3; i++) begin
        d_prod[i] <= 64'(in_beat.d[i]) * 64'(in_beat.hit_time);
      end
    end
  end

  // stage E: scale, add origin, saturate; zero a miss
  out_t   beat_next;
  coord_t pt [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[i] = sat_coord(66'($signed(d_prod[i]) >>> FRAC_BITS) + 66'(d_beat.o[i]));
    end
    if (d_beat.hit) begin
      beat_next.hit      = 1'b1;
      beat_next.hit_time = d_beat.hit_time;
      beat_next.point_x  = pt[0];
      beat_next.point_y  = pt[1];
      beat_next.point_z  = pt[2];
    end else begin
      beat_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= d_valid;
    end
    if (en) begin
      beat <= beat_next;
    end
  end

endmodule

// ===== rtl/ray_box_slab_intersect.sv =====
// Top level of the ray/box slab intersection pipeline.
// Depends on rbs_pkg, rbs_prep, rbs_recip, rbs_slab and rbs_point.
//
//  channel   direction  handshake                 payload
//  in        input      in_valid / in_ready       in_data  (in_t)
//  out       output     out_valid / out_ready     out_data (out_t)
//  cfg       input      cfg_wr_en                 cfg_index, cfg_data
//
// One beat enters per cycle unless the pipeline holds; the reciprocal
// divider forms one quotient bit per stage.
// The whole pipeline advances together; it holds while a result waits
// at the output register and out_ready is low, and in_ready drops then.
// Synchronous reset clears all valid bits and the registers to their
// reset values (segment_mode 0, parallel_threshold 1).
module ray_box_slab_intersect import rbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  logic        segment_mode;
  logic [15:0] parallel_threshold;
  logic        en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_mode       <= 1'b0;
      parallel_threshold <= 16'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SEGMENT_MODE: segment_mode       <= cfg_data[0];
        CFG_PARALLEL_THR: parallel_threshold <= cfg_data[15:0];
      endcase
    end
  end

  // advance everything unless a result is held at the output
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  logic         p_valid;
  prep_t        p_beat;
  logic         r_valid;
  prep_t        r_beat;
  coord_t [2:0] r_recip;
  logic         s_valid;
  slab_t        s_beat;

  rbs_prep u_prep (
    .clk                (clk),
    .rst                (rst),
    .en                 (en),
    .in_valid           (in_valid),
    .in_data            (in_data),
    .segment_mode       (segment_mode),
    .parallel_threshold (parallel_threshold),
    .valid              (p_valid),
    .beat               (p_beat)
  );

  rbs_recip u_recip (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (p_valid),
    .in_beat  (p_beat),
    .valid    (r_valid),
    .beat     (r_beat),
    .recip    (r_recip)
  );

  rbs_slab u_slab (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .segment_mode (segment_mode),
    .in_valid     (r_valid),
    .in_beat      (r_beat),
    .recip        (r_recip),
    .valid        (s_valid),
    .beat         (s_beat)
  );

  rbs_point u_point (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_valid),
    .in_beat  (s_beat),
    .valid    (out_valid),
    .beat     (out_data)
  );

endmodule

// ===== rtl/rbs_checker.sv =====
// Port-level checks for the ray/box slab block, bound to the top level.
// Depends on rbs_pkg and ray_box_slab_intersect_assert.svh.
`include "ray_box_slab_intersect_assert.svh"

module rbs_checker import rbs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a stalled result beat holds
  `RBS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "out beat changed while stalled")

  // a miss carries zero time and point
  `RBS_ASSERT(a_miss_zero, out_valid && !out_data.hit |-> out_data.hit_time == 0 && out_data.point_x == 0 && out_data.point_y == 0 && out_data.point_z == 0, "miss with nonzero fields")

  // input is taken exactly when the output side can move
  `RBS_ASSERT(a_ready_link, in_ready == (!out_valid || out_ready), "in_ready not tied to output stall")

  // reset leaves no result pending
  `RBS_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

bind ray_box_slab_intersect rbs_checker u_rbs_checker (.*);
